>>> hw/rtl/timed_event_queue_macros.svh
// assertion macros used by the checker of the timed event queue
// depends on: a clk and an rst_n signal in the scope that uses them
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// property checked only outside reset
`define TEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define TEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/teq_pkg.sv
// types, codes and sizes of the timed event queue
// depends on: nothing
package teq_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int TAG_BITS    = 16;
  localparam int SLOT_IW     = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int TIME_W      = 64;
  localparam int SEQ_W       = 64;
  localparam int PORT_TAG_W  = 16;

  // command queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    CMD_SCHEDULE  = 2'd0,
    CMD_NEXT_TIME = 2'd1,
    CMD_TAKE      = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TIME = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_SCAN
  } back_state_t;

  // one command as it travels through the queue
  typedef struct packed {
    cmd_t                op;
    logic [TIME_W-1:0]   ev_time;
    logic [TIME_W-1:0]   lim_time;
    logic [TAG_BITS-1:0] tag;
  } item_t;

endpackage

>>> hw/rtl/teq_front.sv
// front end: takes a command transaction, decodes it and hands it to the queue
// depends on: teq_pkg
module teq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic [63:0]         in_event_time,
  input  logic [63:0]         in_limit_time,
  input  logic [15:0]         in_event_tag,
  input  logic                q_full,
  output logic                push,
  output teq_pkg::item_t      push_item
);
  import teq_pkg::*;

  logic  hold_valid_r, hold_valid_nxt;
  item_t hold_r, hold_nxt;
  logic  accept;

  // one holding register; it drains into the queue whenever there is room
  assign push   = hold_valid_r && !q_full;
  assign busy   = hold_valid_r && q_full;
  assign accept = start && !busy;

  // decode the command and keep only the stored tag bits
  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r && !push;
    if (accept) begin
      hold_nxt.op       = cmd_t'(in_command);
      hold_nxt.ev_time  = in_event_time;
      hold_nxt.lim_time = in_limit_time;
      hold_nxt.tag      = TAG_BITS'(in_event_tag);
      hold_valid_nxt    = 1'b1;
    end
  end

  assign push_item = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

>>> hw/rtl/teq_queue.sv
// short command queue between the front end and the slot engine
// depends on: teq_pkg
module teq_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  teq_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output teq_pkg::item_t head_item,
  output logic           not_empty
);
  import teq_pkg::*;

  item_t             entry_r [QUEUE_DEPTH];
  item_t             head_r;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = head_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage; the head is read at the next read pointer, with the incoming
  // transaction passed straight through when it lands on that entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_item;
    end else begin
      head_r <= entry_r[rd_ptr_nxt];
    end
  end

endmodule

>>> hw/rtl/teq_back.sv
// slot engine: holds the event table and walks it one slot a cycle per command
// depends on: teq_pkg
module teq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  teq_pkg::item_t q_head,
  output logic           q_pop,
  output logic           out_strobe,
  output logic [1:0]     out_status,
  output logic [63:0]    out_result_time,
  output logic [15:0]    out_result_tag
);
  import teq_pkg::*;

  back_state_t state_r, state_nxt;
  item_t       op_r, op_nxt;

  // event table
  logic [EVENT_SLOTS-1:0] valid_r;
  logic [TIME_W-1:0]      slot_time_r [EVENT_SLOTS];
  logic [SEQ_W-1:0]       slot_seq_r  [EVENT_SLOTS];
  logic [TAG_BITS-1:0]    slot_tag_r  [EVENT_SLOTS];

  // registered table read, addressed by the next scan pointer so it holds the slot under the scan pointer
  logic [TIME_W-1:0]      rd_time_r;
  logic [SEQ_W-1:0]       rd_seq_r;
  logic [TAG_BITS-1:0]    rd_tag_r;

  logic [SEQ_W-1:0]    seq_ctr_r, seq_ctr_nxt;
  logic [TIME_W-1:0]   cur_time_r, cur_time_nxt;

  // scan state
  logic [SLOT_IW-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0]   best_r, best_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_IW-1:0]  sel_idx_r, sel_idx_nxt;
  logic [SEQ_W-1:0]    sel_seq_r, sel_seq_nxt;
  logic [TAG_BITS-1:0] sel_tag_r, sel_tag_nxt;

  // result register
  logic                out_strobe_r, out_strobe_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;

  // table control
  logic               wr_en, clr_sel, clr_all;
  logic [SLOT_IW-1:0] clr_idx;

  // the slot under the scan pointer
  logic                slot_v, last, take_hit, fin_found;
  logic [TIME_W-1:0]   slot_t, cand;
  logic [SEQ_W-1:0]    slot_s;
  logic [TAG_BITS-1:0] slot_g, fin_tag;
  logic [SLOT_IW-1:0]  fin_idx;

  assign slot_v   = valid_r[idx_r];
  assign slot_t   = rd_time_r;
  assign slot_s   = rd_seq_r;
  assign slot_g   = rd_tag_r;
  assign last     = (idx_r == SLOT_IW'(EVENT_SLOTS - 1));
  assign take_hit = slot_v && (slot_t == op_r.ev_time) && (!found_r || (slot_s < sel_seq_r));
  assign cand     = (slot_v && (slot_t < best_r)) ? slot_t : best_r;
  assign fin_found = found_r || take_hit;
  assign fin_idx   = take_hit ? idx_r : sel_idx_r;
  assign fin_tag   = take_hit ? slot_g : sel_tag_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        case (op_r.op)
          CMD_SCHEDULE: begin
            if ((op_r.ev_time < cur_time_r) || (seq_ctr_r == '1)) begin
              state_nxt = BK_IDLE;
            end else begin
              state_nxt = BK_SCAN;
            end
          end
          CMD_CLEAR: state_nxt = BK_IDLE;
          default:   state_nxt = BK_SCAN;
        endcase
      end
      BK_SCAN: begin
        if (last || ((op_r.op == CMD_SCHEDULE) && !slot_v)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop          = 1'b0;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    sel_idx_nxt    = sel_idx_r;
    sel_seq_nxt    = sel_seq_r;
    sel_tag_nxt    = sel_tag_r;
    seq_ctr_nxt    = seq_ctr_r;
    cur_time_nxt   = cur_time_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_time_nxt   = out_time_r;
    out_tag_nxt    = out_tag_r;
    wr_en          = 1'b0;
    clr_sel        = 1'b0;
    clr_all        = 1'b0;
    clr_idx        = fin_idx;
    case (state_r)
      BK_IDLE: begin
        q_pop  = q_not_empty;
        op_nxt = q_head;
      end
      BK_CHECK: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        best_nxt  = op_r.lim_time;
        case (op_r.op)
          CMD_SCHEDULE: begin
            if (op_r.ev_time < cur_time_r) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_BAD_TIME;
              out_time_nxt   = '0;
              out_tag_nxt    = '0;
            end else if (seq_ctr_r == '1) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_FULL;
              out_time_nxt   = '0;
              out_tag_nxt    = '0;
            end
          end
          CMD_CLEAR: begin
            clr_all        = 1'b1;
            seq_ctr_nxt    = '0;
            cur_time_nxt   = '0;
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_OK;
            out_time_nxt   = '0;
            out_tag_nxt    = '0;
          end
          default: begin
          end
        endcase
      end
      BK_SCAN: begin
        idx_nxt = idx_r + SLOT_IW'(1);
        case (op_r.op)
          // first free slot takes the event
          CMD_SCHEDULE: begin
            if (!slot_v) begin
              wr_en          = 1'b1;
              seq_ctr_nxt    = seq_ctr_r + SEQ_W'(1);
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_OK;
              out_time_nxt   = '0;
              out_tag_nxt    = '0;
            end else if (last) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_FULL;
              out_time_nxt   = '0;
              out_tag_nxt    = '0;
            end
          end
          // running minimum, seeded with the limit
          CMD_NEXT_TIME: begin
            best_nxt = cand;
            if (last) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_OK;
              out_time_nxt   = cand;
              out_tag_nxt    = '0;
            end
          end
          // exact time match with the oldest sequence wins
          CMD_TAKE: begin
            if (take_hit) begin
              found_nxt   = 1'b1;
              sel_idx_nxt = idx_r;
              sel_seq_nxt = slot_s;
              sel_tag_nxt = slot_g;
            end
            if (last) begin
              out_strobe_nxt = 1'b1;
              if (fin_found) begin
                clr_sel        = 1'b1;
                cur_time_nxt   = (op_r.ev_time > cur_time_r) ? op_r.ev_time : cur_time_r;
                out_status_nxt = ST_OK;
                out_time_nxt   = op_r.ev_time;
                out_tag_nxt    = fin_tag;
              end else begin
                out_status_nxt = ST_NONE;
                out_time_nxt   = '0;
                out_tag_nxt    = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      valid_r      <= '0;
      seq_ctr_r    <= '0;
      cur_time_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seq_ctr_r    <= seq_ctr_nxt;
      cur_time_r   <= cur_time_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (clr_all) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[idx_r] <= 1'b1;
      end else if (clr_sel) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  // payload registers and slot contents
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    found_r      <= found_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_seq_r    <= sel_seq_nxt;
    sel_tag_r    <= sel_tag_nxt;
    out_status_r <= out_status_nxt;
    out_time_r   <= out_time_nxt;
    out_tag_r    <= out_tag_nxt;
    if (wr_en) begin
      slot_time_r[idx_r] <= op_r.ev_time;
      slot_seq_r[idx_r]  <= seq_ctr_r;
      slot_tag_r[idx_r]  <= op_r.tag;
    end
    // read the slot the scan pointer moves to
    rd_time_r <= slot_time_r[idx_nxt];
    rd_seq_r  <= slot_seq_r[idx_nxt];
    rd_tag_r  <= slot_tag_r[idx_nxt];
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_result_time = out_time_r;
  assign out_result_tag  = PORT_TAG_W'(out_tag_r);

endmodule

>>> hw/rtl/timed_event_queue.sv
// top level of the timed event queue: front end, command queue and slot engine
// depends on: teq_pkg, teq_front, teq_queue, teq_back
//
// A command transaction (schedule, next due time, take, clear) is accepted on
// a rising edge with start high and busy low. Each command gives exactly one
// result, shown on out_status, out_result_time and out_result_tag for one
// cycle with out_strobe high; the receiver cannot hold it off.
// The front end registers the command and drops it into a two-entry queue;
// busy rises only while its holding register waits on a full queue.
// The slot engine walks the 16-slot table one slot a cycle, so the scan of
// the table sets the rate: next-time and take go through pop, check and
// every slot, a schedule stops at the first free slot (the last if none is
// free), and a clear or a rejected schedule ends after pop and check.
// Reset (rst_n low at a clock edge) empties the table, zeroes the sequence
// counter and current time, and drops any queued command.
module timed_event_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_event_time,
  input  logic [63:0] in_limit_time,
  input  logic [15:0] in_event_tag,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [63:0] out_result_time,
  output logic [15:0] out_result_tag
);
  import teq_pkg::*;

  item_t push_item, head_item;
  logic  push, q_full, q_pop, q_not_empty;

  // command intake
  teq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_event_time (in_event_time),
    .in_limit_time (in_limit_time),
    .in_event_tag  (in_event_tag),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  teq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty)
  );

  // slot engine
  teq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (head_item),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_result_time (out_result_time),
    .out_result_tag  (out_result_tag)
  );

endmodule

>>> hw/rtl/teq_checker.sv
// port-level checker for the timed event queue, bound to the top level
// depends on: teq_pkg, timed_event_queue_macros.svh
`include "timed_event_queue_macros.svh"

module teq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [63:0] out_result_time,
  input logic [15:0] out_result_tag
);
  import teq_pkg::*;

  // reset leaves no result and no back-pressure behind
  `TEQ_ASSERT_ALWAYS(a_rst_no_strobe, !rst_n |=> !out_strobe, "result strobe after reset")
  `TEQ_ASSERT_ALWAYS(a_rst_not_busy, !rst_n |=> !busy, "busy right after reset")

  // every command passes through pop and check, so results never come back to back
  `TEQ_ASSERT(a_strobe_single, out_strobe |=> !out_strobe, "results on adjacent cycles")

  // failed commands carry no time and no tag
  `TEQ_ASSERT(a_fail_zero,
    (out_strobe && (out_status != ST_OK)) |-> ((out_result_time == '0) && (out_result_tag == '0)),
    "failed command returned data")

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);
